FILE: hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque core
// Request codes, status codes and the word type used across the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	// Width of one stored word.
	localparam int unsigned WordW = 32;

	// Request codes carried on the op port.
	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5
	} op_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic [WordW-1:0] word_t;

endpackage

`default_nettype wire

FILE: hdl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram: ring storage of the deque
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic           clk,
	input  wire logic           we,
	input  wire logic           re,
	input  wire logic [AW-1:0]  addr,
	input  wire cdq_pkg::word_t wdata,
	output cdq_pkg::word_t      rdata
);

	cdq_pkg::word_t mem [DEPTH];
	cdq_pkg::word_t rdata_q;

	// One access per cycle: either a write or a read of the addressed entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: pointer and flag control of the deque
// Decodes each request, updates the pointers and issues the memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [2:0]     op,
	output logic                busy,
	output logic                mem_we,
	output logic                mem_re,
	output logic [AW-1:0]       mem_addr,
	output logic                done,
	output logic                rd_sel,
	output logic [1:0]          status,
	output logic                is_empty,
	output logic                is_full
);

	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	logic [AW-1:0] front_q, back_q, front_n, back_n;
	logic          empty_q, empty_n;
	logic          ready_q;
	logic          accept;
	logic          full_now;
	cdq_pkg::status_t st_n;

	logic             done_s1;
	logic             rd_sel_s1;
	cdq_pkg::status_t status_s1;
	logic             empty_s1;
	logic             full_s1;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == LastIdx) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		ptr_prev = (p == '0) ? LastIdx : p - AW'(1);
	endfunction

	assign accept   = start & ready_q;
	assign busy     = ~ready_q;
	assign full_now = ~empty_q && (ptr_next(back_q) == front_q);

	// Request decode: next pointers, status and the memory access.
	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		empty_n  = empty_q;
		st_n     = cdq_pkg::ST_OK;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = front_q;
		case (op)
			cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
				if (full_now) begin
					st_n = cdq_pkg::ST_FULL;
				end else if (empty_q) begin
					front_n  = '0;
					back_n   = '0;
					empty_n  = 1'b0;
					mem_we   = accept;
					mem_addr = '0;
				end else if (op == cdq_pkg::OP_PUSH_BACK) begin
					back_n   = ptr_next(back_q);
					mem_we   = accept;
					mem_addr = back_n;
				end else begin
					front_n  = ptr_prev(front_q);
					mem_we   = accept;
					mem_addr = front_n;
				end
			end
			cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK,
			cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_BACK: begin
				if (empty_q) begin
					st_n = cdq_pkg::ST_EMPTY;
				end else begin
					mem_re = accept;
					if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_PEEK_FRONT) begin
						mem_addr = front_q;
					end else begin
						mem_addr = back_q;
					end
					if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_BACK) begin
						if (front_q == back_q) begin
							front_n = '0;
							back_n  = '0;
							empty_n = 1'b1;
						end else if (op == cdq_pkg::OP_POP_FRONT) begin
							front_n = ptr_next(front_q);
						end else begin
							back_n = ptr_prev(back_q);
						end
					end
				end
			end
			default: begin
				st_n = cdq_pkg::ST_OK;
			end
		endcase
	end

	// Pointer state, updated only when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			empty_q <= 1'b1;
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			if (accept) begin
				front_q <= front_n;
				back_q  <= back_n;
				empty_q <= empty_n;
			end
		end
	end

	// Result stage, aligned with the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1   <= 1'b0;
			rd_sel_s1 <= 1'b0;
		end else begin
			done_s1   <= accept;
			rd_sel_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= st_n;
		empty_s1  <= empty_n;
		full_s1   <= ~empty_n && (ptr_next(back_n) == front_n);
	end

	assign done     = done_s1;
	assign rd_sel   = rd_sel_s1;
	assign status   = status_s1;
	assign is_empty = empty_s1;
	assign is_full  = full_s1;

endmodule

`default_nettype wire

FILE: hdl/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue of signed words in a ring memory
// Push, pop and peek at either end, with status and empty/full flags.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  request   start, busy      op, value
//  result    done (strobe)    data_out, status, is_empty, is_full
//
// A request is taken on a rising edge with start high and busy low; its result
// is shown with done high for exactly one cycle, in the cycle after it was taken.
// A new request may be taken every cycle: the single-port ring memory serves
// one read or one write per request, and pointers update on the taking edge.
// Busy is high only in the first cycle after reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_core #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic signed [31:0]      data_out,
	output logic [1:0]              status,
	output logic                    is_empty,
	output logic                    is_full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_addr;
	logic           rd_sel;
	cdq_pkg::word_t rdata;

	// Pointer control and result registers.
	cdq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op),
		.busy     (busy),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.done     (done),
		.rd_sel   (rd_sel),
		.status   (status),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

	// Ring storage.
	cdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (cdq_pkg::word_t'(value)),
		.rdata (rdata)
	);

	// Data is zero unless the request read an entry.
	assign data_out = rd_sel ? signed'(rdata) : '0;

endmodule

`default_nettype wire

FILE: tb/tb_circular_deque_core.sv
// ----------------------------------------------------------------------------
// tb_circular_deque_core: self-checking bench for the circular deque core
// Walks a directed table of requests over the empty, full and wrap-around
// corners, then runs random request bursts that fill and drain the ring.
// Each result is checked field by field against a behavioural deque model,
// or against a value typed into the table where the answer is obvious.
// ----------------------------------------------------------------------------
module tb_circular_deque_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned IDLE_PCT    = 19;
	localparam int unsigned RAND_ITEMS  = 1040;
	localparam int unsigned CYCLE_LIMIT = 60000;

	// Request codes that the block must answer without touching the ring.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		cdq_pkg::word_t   data;
		cdq_pkg::status_t status;
		logic             empty;
		logic             full;
	} res_t;

	typedef struct packed {
		logic [2:0]     code;
		cdq_pkg::word_t val;
		logic [4:0]     reps;
		logic           pinned;
		res_t           want;
	} row_t;

	localparam res_t NO_PIN     = '0;
	localparam res_t EMPTY_REFD = '{32'd0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0};
	localparam res_t IDLE_OK    = '{32'd0, cdq_pkg::ST_OK, 1'b1, 1'b0};
	localparam res_t PUSH_OK    = '{32'd0, cdq_pkg::ST_OK, 1'b0, 1'b0};
	localparam res_t FULL_REFD  = '{32'd0, cdq_pkg::ST_FULL, 1'b0, 1'b1};

	localparam int NROWS = 26;

	// Directed requests: empty refusals, spare codes, extreme words at both
	// ends, emptying by the last pop, wrap of the front below entry zero,
	// filling to the brim, full refusals and a complete drain.
	row_t script [NROWS] = '{
		'{cdq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1, EMPTY_REFD},
		'{cdq_pkg::OP_POP_FRONT,  32'h1234_5678, 5'd1, 1'b1, EMPTY_REFD},
		'{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, EMPTY_REFD},
		'{cdq_pkg::OP_PEEK_BACK,  32'hFFFF_FFFF, 5'd1, 1'b1, EMPTY_REFD},
		'{OP_SPARE_6,             32'hFFFF_FFFF, 5'd1, 1'b1, IDLE_OK},
		'{OP_SPARE_7,             32'hA5A5_A5A5, 5'd1, 1'b1, IDLE_OK},
		'{cdq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 5'd1, 1'b1, PUSH_OK},
		'{cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, PUSH_OK},
		'{cdq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h8000_0000, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b1,
			'{32'h7FFF_FFFF, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
			'{32'h8000_0000, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
			'{32'h7FFF_FFFF, cdq_pkg::ST_OK, 1'b1, 1'b0}},
		'{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1, 1'b1, PUSH_OK},
		'{cdq_pkg::OP_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b1,
			'{32'hFFFF_FFFF, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
			'{32'hFFFF_FFFF, cdq_pkg::ST_OK, 1'b1, 1'b0}},
		'{cdq_pkg::OP_PUSH_FRONT, 32'h0000_1000, 5'd8, 1'b0, NO_PIN},
		'{cdq_pkg::OP_PUSH_BACK,  32'h0000_2000, 5'd7, 1'b0, NO_PIN},
		'{cdq_pkg::OP_PUSH_BACK,  32'h5555_5555, 5'd1, 1'b1,
			'{32'd0, cdq_pkg::ST_OK, 1'b0, 1'b1}},
		'{cdq_pkg::OP_PUSH_BACK,  32'h0000_0001, 5'd1, 1'b1, FULL_REFD},
		'{cdq_pkg::OP_PUSH_FRONT, 32'h0000_0002, 5'd1, 1'b1, FULL_REFD},
		'{cdq_pkg::OP_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b1,
			'{32'h5555_5555, cdq_pkg::ST_OK, 1'b0, 1'b1}},
		'{OP_SPARE_6,             32'h0000_0000, 5'd1, 1'b1,
			'{32'd0, cdq_pkg::ST_OK, 1'b0, 1'b1}},
		'{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
			'{32'h5555_5555, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd14, 1'b0, NO_PIN},
		'{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b0, NO_PIN},
		'{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, EMPTY_REFD}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [2:0]        op = 3'd0;
	logic signed [31:0] value = 32'sd0;
	logic              busy;
	logic              done;
	logic signed [31:0] data_out;
	logic [1:0]        status;
	logic              is_empty;
	logic              is_full;

	// Typed expectation that travels with the request it belongs to.
	logic pin_valid = 1'b0;
	res_t pin_res   = '0;

	// Deque model state and the results still owed by the block.
	cdq_pkg::word_t shadow_words [DEPTH];
	int unsigned    head_pos     = 0;
	int unsigned    tail_pos     = 0;
	bit             shadow_empty = 1'b1;
	res_t           owed_results [$];

	int unsigned fails         = 0;
	int unsigned cycles        = 0;
	int unsigned n_requests    = 0;
	int unsigned n_full_refd   = 0;
	int unsigned n_empty_refd  = 0;
	int unsigned n_full_states = 0;
	bit          allow_idle    = 1'b1;

	circular_deque_core #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.value    (value),
		.done     (done),
		.data_out (data_out),
		.status   (status),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slot_after(input int unsigned p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic int unsigned slot_before(input int unsigned p);
		return (p == 0) ? DEPTH - 1 : p - 1;
	endfunction

	function automatic bit ring_brim();
		return !shadow_empty && slot_after(tail_pos) == head_pos;
	endfunction

	// Applies one request to the deque model and returns the answer it owes.
	function automatic res_t deque_apply(input logic [2:0] code,
			input cdq_pkg::word_t val);
		res_t r;
		bit   front_end;
		r = '0;
		r.status = cdq_pkg::ST_OK;
		front_end = (code == cdq_pkg::OP_POP_FRONT) || (code == cdq_pkg::OP_PEEK_FRONT);
		case (code)
			cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
				if (ring_brim()) begin
					r.status = cdq_pkg::ST_FULL;
				end else if (shadow_empty) begin
					head_pos = 0;
					tail_pos = 0;
					shadow_words[0] = val;
					shadow_empty = 1'b0;
				end else if (code == cdq_pkg::OP_PUSH_BACK) begin
					tail_pos = slot_after(tail_pos);
					shadow_words[tail_pos] = val;
				end else begin
					head_pos = slot_before(head_pos);
					shadow_words[head_pos] = val;
				end
			end
			cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK,
			cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_BACK: begin
				if (shadow_empty) begin
					r.status = cdq_pkg::ST_EMPTY;
				end else begin
					r.data = shadow_words[front_end ? head_pos : tail_pos];
					if (code == cdq_pkg::OP_POP_FRONT || code == cdq_pkg::OP_POP_BACK) begin
						if (head_pos == tail_pos) begin
							shadow_empty = 1'b1;
							head_pos = 0;
							tail_pos = 0;
						end else if (front_end) begin
							head_pos = slot_after(head_pos);
						end else begin
							tail_pos = slot_before(tail_pos);
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.empty = shadow_empty;
		r.full  = ring_brim();
		return r;
	endfunction

	// Random request code: push_pct out of a hundred are pushes, a few are
	// spare codes, and the rest are pops and peeks at either end.
	function automatic logic [2:0] pick_code(input int unsigned push_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
		if (r < 2 + push_pct)
			return ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_PUSH_FRONT
				: cdq_pkg::OP_PUSH_BACK;
		case ($urandom_range(0, 3))
			0:       return cdq_pkg::OP_POP_FRONT;
			1:       return cdq_pkg::OP_POP_BACK;
			2:       return cdq_pkg::OP_PEEK_FRONT;
			default: return cdq_pkg::OP_PEEK_BACK;
		endcase
	endfunction

	// Random word, weighted towards the extremes and small values.
	function automatic cdq_pkg::word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			4:       return cdq_pkg::word_t'($urandom_range(0, 255));
			default: return cdq_pkg::word_t'($urandom);
		endcase
	endfunction

	// Offers one request, with random idle cycles first, and returns on the
	// edge at which the block takes it.
	task automatic send_request(input logic [2:0] code, input cdq_pkg::word_t val,
			input logic pinned, input res_t want);
		while (allow_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		op        <= code;
		value     <= val;
		pin_valid <= pinned;
		pin_res   <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Holds requests back until every owed result has come in.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (owed_results.size() != 0);
		@(posedge clk);
	endtask

	// Result checker and request tracker, both sampled on the rising edge.
	always @(posedge clk) begin : watch
		res_t want;
		res_t model;
		if (arst_n) begin
			if (done) begin
				if (owed_results.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					want = owed_results.pop_front();
					if (data_out !== want.data) begin
						$error("data_out: expected %h, got %h", want.data, data_out);
						fails++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (is_empty !== want.empty) begin
						$error("is_empty: expected %b, got %b", want.empty, is_empty);
						fails++;
					end
					if (is_full !== want.full) begin
						$error("is_full: expected %b, got %b", want.full, is_full);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				model = deque_apply(op, value);
				n_requests++;
				if (model.status == cdq_pkg::ST_FULL)
					n_full_refd++;
				if (model.status == cdq_pkg::ST_EMPTY)
					n_empty_refd++;
				if (model.full)
					n_full_states++;
				owed_results.push_back(pin_valid ? pin_res : model);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("circular_deque_core: mismatch");
			$finish;
		end
	end

	// Stimulus: reset, directed table, random bursts, then the final check.
	initial begin : stimulus
		int unsigned taken;
		int unsigned burst;
		int unsigned push_pct;
		int unsigned guard;
		logic [2:0]  code;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NROWS; i++) begin
			for (int k = 0; k < script[i].reps; k++)
				send_request(script[i].code, script[i].val + cdq_pkg::word_t'(k),
					script[i].pinned, script[i].want);
		end
		drain_results();

		// Bursts with a fixed lean towards filling, draining or neither.
		taken = 0;
		burst = 0;
		push_pct = 40;
		while (taken < RAND_ITEMS) begin
			if (burst == 0) begin
				burst = $urandom_range(8, 40);
				case ($urandom_range(0, 2))
					0:       push_pct = 75;
					1:       push_pct = 15;
					default: push_pct = 40;
				endcase
			end
			allow_idle = !(taken >= 300 && taken < 550);
			if (taken == 700)
				drain_results();
			code = pick_code(push_pct);
			send_request(code, pick_word(), 1'b0, NO_PIN);
			if (code != OP_SPARE_6 && code != OP_SPARE_7)
				taken++;
			burst--;
		end

		start <= 1'b0;
		guard = 0;
		while (owed_results.size() != 0 && guard < 50) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			fails += owed_results.size();
		end

		$display("Ran %0d requests; the ring was full after %0d of them.",
			n_requests, n_full_states);
		$display("Refused %0d pushes as full and %0d pops or peeks as empty.",
			n_full_refd, n_empty_refd);
		if (fails == 0) begin
			$display("circular_deque_core: match");
		end else begin
			$display("circular_deque_core: mismatch");
		end
		$finish;
	end

endmodule
